// File: hw/rtl/crlm_pkg.sv
package crlm_pkg;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 3;

  localparam int NUM_W = 62;
  localparam int DEN_W = 63;
  localparam int CNT_W = 6;
  localparam int RATE_ITERS = 62;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 30;
  localparam logic [MUL_B_W-1:0] NS_PER_S = 30'd1000000000;

  localparam int EARLY_DIV = 20;
  localparam logic [16:0] PKT_TOTAL_MAX = 17'h1FFFF;
  localparam logic [13:0] LOSS_MAX = 14'h3FFF;

  localparam logic [1:0] STAT_USE   = 2'd0;
  localparam logic [1:0] STAT_EARLY = 2'd1;
  localparam logic [1:0] STAT_NEW   = 2'd2;
  localparam logic [1:0] STAT_STALE = 2'd3;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: hw/rtl/crlm_div.sv
module crlm_div import crlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0] rem_s;
  logic [DEN_W:0] rem_d;
  logic           ge;

  // restoring step: numerator bits shift out the top, quotient bits shift in
  always_comb begin
    rem_s = {rem_r[DEN_W-1:0], n_r[NUM_W-1]};
    ge    = rem_s >= {1'b0, den_r};
    rem_d = rem_s - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.num << (CNT_W'(NUM_W) - req.iters);
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      n_r   <= {n_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_d : rem_s;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = n_r;

endmodule

// File: hw/rtl/chirp_rate_loss_meter.sv
// channel | direction | tdata (low bit up)                         | tuser
// in_     | slave     | chirp_number[31:0] packet_number[47:32]    | -
//         |           | chirp_length[63:48] packet_length[79:64]   |
//         |           | receive_time_ns[142:80], pad[143]          |
// out_    | master    | rate[61:0] loss[75:62], pad[79:76]         | status[1:0]
//         |           |                                            | values_valid[2]
// One word at a time; in_tready is low from acceptance until the result is registered.
// Stale word: PREP, OUT. New chirp: PREP, OUT; closing a chirp adds LOSS, plus LDIV and
// LWAIT when its loss is nonzero.
// Same-chirp word: PREP, RMUL, RDIV, RWAIT, LOSS, LDIV, LWAIT, OUT (rate steps only if
// the span is positive). A single 1-bit-per-cycle divider is shared by rate and loss.
// The next word is taken while a result waits on out_tready; a stalled result holds the
// sequencer in its last step. rst_n is synchronous and clears all measurement state.
module chirp_rate_loss_meter import crlm_pkg::*; #(
  parameter int LOSS_SCALE = 10000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // chirp_number, packet_number, chirp_length,
                                            // packet_length, receive_time_ns
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // rate, loss
  output logic [OUT_USER_W-1:0] out_tuser   // status, values_valid
);

  localparam int LOSS_ITERS = 16 + $clog2(LOSS_SCALE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_RMUL  = 4'd2;
  localparam logic [3:0] S_RDIV  = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_LOSS  = 4'd5;
  localparam logic [3:0] S_LDIV  = 4'd6;
  localparam logic [3:0] S_LWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [31:0] cur_chirp_r;
  logic [31:0] byte_total_r;
  logic [16:0] pkt_total_r;
  logic [62:0] start_time_r;
  logic [15:0] exp_pkts_r;
  logic [61:0] run_rate_r;

  logic [31:0] chirp_in_r;
  logic [15:0] pkt_in_r;
  logic [15:0] clen_in_r;
  logic [15:0] plen_in_r;
  logic [62:0] time_in_r;

  logic [62:0] span_r;
  logic [61:0] prod_r;
  logic [16:0] rcv_r;
  logic [15:0] snt_r;

  logic [1:0]  res_status_r;
  logic        res_valid_r;
  logic [61:0] res_rate_r;
  logic [13:0] res_loss_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  logic        in_acc;
  logic        out_free;
  logic        is_stale, is_new;
  logic [16:0] pt_next;
  logic [32:0] bt_sum;
  logic [31:0] bt_next;
  logic        span_pos;
  logic        early;
  logic        loss_zero;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [61:0] mul_prod;
  logic [13:0] loss_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    is_stale  = chirp_in_r < cur_chirp_r;
    is_new    = chirp_in_r > cur_chirp_r;
    pt_next   = (pkt_total_r == PKT_TOTAL_MAX) ? pkt_total_r : pkt_total_r + 17'd1;
    bt_sum    = {1'b0, byte_total_r} + 33'(plen_in_r);
    bt_next   = bt_sum[32] ? 32'hFFFF_FFFF : bt_sum[31:0];
    span_pos  = time_in_r > start_time_r;
    early     = (21'(pkt_in_r) + 21'd1) * 21'(EARLY_DIV) <= 21'(exp_pkts_r);
    loss_zero = (snt_r == 16'd0) || (rcv_r >= {1'b0, snt_r});
    if (state_r == S_RMUL) begin
      mul_a = byte_total_r;
      mul_b = NS_PER_S;
    end else begin
      mul_a = MUL_A_W'(snt_r - rcv_r[15:0]);
      mul_b = MUL_B_W'(LOSS_SCALE);
    end
    mul_prod = 62'(mul_a) * 62'(mul_b);
    loss_q   = (div_rsp.quo > 62'(LOSS_MAX)) ? LOSS_MAX : div_rsp.quo[13:0];
  end

  always_comb begin
    div_req.start = (state_r == S_RDIV) || (state_r == S_LDIV);
    div_req.num   = prod_r;
    if (state_r == S_RDIV) begin
      div_req.den   = span_r;
      div_req.iters = CNT_W'(RATE_ITERS);
    end else begin
      div_req.den   = DEN_W'(snt_r);
      div_req.iters = CNT_W'(LOSS_ITERS);
    end
  end

  crlm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (is_stale) state_nxt = S_OUT;
        else if (is_new) state_nxt = (cur_chirp_r != 32'd0) ? S_LOSS : S_OUT;
        else state_nxt = span_pos ? S_RMUL : S_LOSS;
      end
      S_RMUL:  state_nxt = S_RDIV;
      S_RDIV:  state_nxt = S_RWAIT;
      S_RWAIT: begin
        if (div_rsp.done) state_nxt = S_LOSS;
      end
      S_LOSS:  state_nxt = loss_zero ? S_OUT : S_LDIV;
      S_LDIV:  state_nxt = S_LWAIT;
      S_LWAIT: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cur_chirp_r  <= '0;
      byte_total_r <= '0;
      pkt_total_r  <= '0;
      start_time_r <= '0;
      exp_pkts_r   <= '0;
      run_rate_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (state_r == S_PREP && !is_stale) begin
        if (is_new) begin
          cur_chirp_r  <= chirp_in_r;
          byte_total_r <= '0;
          start_time_r <= time_in_r;
          pkt_total_r  <= 17'd1;
          exp_pkts_r   <= clen_in_r;
        end else begin
          pkt_total_r  <= pt_next;
          byte_total_r <= bt_next;
          if (!span_pos) run_rate_r <= 62'd1;
        end
      end
      if (state_r == S_RWAIT && div_rsp.done) run_rate_r <= div_rsp.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chirp_in_r <= in_tdata[31:0];
      pkt_in_r   <= in_tdata[47:32];
      clen_in_r  <= in_tdata[63:48];
      plen_in_r  <= in_tdata[79:64];
      time_in_r  <= in_tdata[142:80];
    end
    case (state_r)
      S_PREP: begin
        span_r     <= time_in_r - start_time_r;
        res_loss_r <= '0;
        if (is_stale) begin
          res_status_r <= STAT_STALE;
          res_valid_r  <= 1'b0;
          res_rate_r   <= '0;
        end else if (is_new) begin
          res_status_r <= STAT_NEW;
          res_valid_r  <= (cur_chirp_r != 32'd0);
          res_rate_r   <= (cur_chirp_r != 32'd0) ? run_rate_r : 62'd0;
          rcv_r        <= pkt_total_r;
          snt_r        <= exp_pkts_r;
        end else begin
          res_status_r <= early ? STAT_EARLY : STAT_USE;
          res_valid_r  <= 1'b1;
          res_rate_r   <= 62'd1;
          rcv_r        <= pt_next;
          snt_r        <= pkt_in_r;
        end
      end
      S_RMUL, S_LOSS: prod_r <= mul_prod;
      S_RWAIT: begin
        if (div_rsp.done) res_rate_r <= div_rsp.quo;
      end
      S_LWAIT: begin
        if (div_rsp.done) res_loss_r <= loss_q;
      end
      S_OUT: begin
        if (out_free) begin
          out_tdata_r <= {4'b0, res_loss_r, res_rate_r};
          out_tuser_r <= {res_valid_r, res_status_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: hw/rtl/crlm_chk.sv
module crlm_chk import crlm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the word was processed");

  a_stale_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == STAT_STALE |-> !out_tuser[2])
    else $error("stale word flagged with values");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[75:0] == 76'd0)
    else $error("rate or loss nonzero without values");

  a_same_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == STAT_USE || out_tuser[1:0] == STAT_EARLY)
      |-> out_tuser[2])
    else $error("same-chirp word without values");

endmodule

bind chirp_rate_loss_meter crlm_chk u_crlm_chk (.*);
